FILE: hdl/mdiomm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdiomm_pkg
// Types and constants shared by the MDIO management master modules.
// ----------------------------------------------------------------------------
package mdiomm_pkg;

    // Longest preamble the engine sends; larger settings saturate here.
    localparam logic [5:0] C_MAX_PREAMBLE = 6'd32;

    // Register reset values.
    localparam logic [9:0] C_HALF_PERIOD_RESET = 10'd10;
    localparam logic [5:0] C_PREAMBLE_RESET    = 6'd1;

    // ST + opcode nibble of the header: 01 10 read, 01 01 write.
    localparam logic [3:0] C_CODE_READ  = 4'b0110;
    localparam logic [3:0] C_CODE_WRITE = 4'b0101;

    // Register indexes (word address on the config port).
    typedef enum logic {
        REG_HALF_PERIOD = 1'b0,
        REG_PREAMBLE    = 1'b1
    } t_reg_index;

    // Item kinds.
    typedef enum logic {
        KIND_TICK    = 1'b0,
        KIND_COMMAND = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        is_write;
        logic [4:0]  phy_address;
        logic [4:0]  register_address;
        logic [15:0] write_value;
        logic        mdio_sample;
    } t_item;

    typedef struct packed {
        logic        mdc_level;
        logic        mdio_drive;
        logic        mdio_enable;
        logic        busy_res;
        logic        frame_done;
        logic [15:0] read_value;
        logic        command_rejected;
    } t_result;

    typedef struct packed {
        logic [9:0] half_period_ticks;
        logic [5:0] preamble_ones;
    } t_cfg;

endpackage

FILE: hdl/mdiomm_apb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdiomm_apb_regs
// APB register file: MDC half period and preamble length.
// ----------------------------------------------------------------------------
module mdiomm_apb_regs
    import mdiomm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [9:0] r_half_period;
    logic [5:0] r_preamble;
    logic       wr_en;
    t_reg_index idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = t_reg_index'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= C_HALF_PERIOD_RESET;
            r_preamble    <= C_PREAMBLE_RESET;
        end else if (wr_en) begin
            unique case (idx)
                REG_HALF_PERIOD: r_half_period <= pwdata[9:0];
                REG_PREAMBLE:    r_preamble    <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_HALF_PERIOD: prdata = {22'd0, r_half_period};
            REG_PREAMBLE:    prdata = {26'd0, r_preamble};
            default:         prdata = 32'd0;
        endcase
    end

    assign o_cfg.half_period_ticks = r_half_period;
    assign o_cfg.preamble_ones     = r_preamble;

endmodule

FILE: hdl/mdiomm_frame_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdiomm_frame_engine
// Frame state and per-beat update: MDC divider, slot counter, MDIO drive.
// ----------------------------------------------------------------------------
module mdiomm_frame_engine
    import mdiomm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    logic        r_active, n_active;
    logic        r_write_mode, n_write_mode;
    logic [6:0]  r_bit_pos, n_bit_pos;
    logic [9:0]  r_tick_count, n_tick_count;
    logic        r_clock_level, n_clock_level;
    logic [13:0] r_header, n_header;
    logic [15:0] r_data_shift, n_data_shift;
    logic [15:0] r_captured, n_captured;

    logic [5:0]  pre;
    logic [6:0]  pre7;
    logic [9:0]  half_period;
    logic [6:0]  b_header;   // first header slot
    logic [6:0]  b_turn;     // first turnaround slot
    logic [6:0]  b_data;     // first data slot
    logic [6:0]  b_idle;     // first trailing idle slot
    logic [6:0]  b_end;      // frame length in slots
    logic [6:0]  hdr_off;
    logic [6:0]  dat_off;
    logic        done;
    logic        rejected;
    logic        drv;
    logic        en;

    assign pre         = (i_cfg.preamble_ones > C_MAX_PREAMBLE) ? C_MAX_PREAMBLE
                                                                 : i_cfg.preamble_ones;
    assign pre7        = {1'b0, pre};
    assign half_period = (i_cfg.half_period_ticks == 10'd0) ? 10'd1
                                                             : i_cfg.half_period_ticks;
    assign b_header    = pre7 + 7'd1;
    assign b_turn      = pre7 + 7'd15;
    assign b_data      = pre7 + 7'd17;
    assign b_idle      = pre7 + 7'd33;
    assign b_end       = pre7 + 7'd35;

    // Next state
    always_comb begin
        n_active      = r_active;
        n_write_mode  = r_write_mode;
        n_bit_pos     = r_bit_pos;
        n_tick_count  = r_tick_count;
        n_clock_level = r_clock_level;
        n_header      = r_header;
        n_data_shift  = r_data_shift;
        n_captured    = r_captured;
        done          = 1'b0;
        rejected      = 1'b0;
        if (i_step) begin
            if (i_item.kind == KIND_COMMAND) begin
                if (r_active) begin
                    rejected = 1'b1;
                end else begin
                    n_write_mode  = i_item.is_write;
                    n_header      = {(i_item.is_write ? C_CODE_WRITE : C_CODE_READ),
                                     i_item.phy_address, i_item.register_address};
                    n_data_shift  = i_item.is_write ? i_item.write_value : 16'd0;
                    n_active      = 1'b1;
                    n_bit_pos     = 7'd0;
                    n_tick_count  = 10'd0;
                    n_clock_level = 1'b0;
                end
            end else if (r_active) begin
                n_tick_count = r_tick_count + 10'd1;
                if (n_tick_count >= half_period) begin
                    n_tick_count = 10'd0;
                    if (!r_clock_level) begin
                        // rising edge: sample read data
                        if (!r_write_mode && r_bit_pos >= b_data && r_bit_pos < b_idle) begin
                            n_data_shift = {r_data_shift[14:0], i_item.mdio_sample};
                        end
                        n_clock_level = 1'b1;
                    end else begin
                        // falling edge: next slot
                        n_clock_level = 1'b0;
                        n_bit_pos     = r_bit_pos + 7'd1;
                        if (n_bit_pos >= b_end) begin
                            if (!r_write_mode) begin
                                n_captured = r_data_shift;
                            end
                            n_active  = 1'b0;
                            n_bit_pos = 7'd0;
                            done      = 1'b1;
                        end
                    end
                end
            end
        end
    end

    // MDIO drive for the slot after this beat
    assign hdr_off = b_turn - 7'd1 - n_bit_pos;
    assign dat_off = b_idle - 7'd1 - n_bit_pos;

    always_comb begin
        drv = 1'b0;
        en  = 1'b0;
        if (!n_active || n_bit_pos == 7'd0) begin
            en = 1'b0;
        end else if (n_bit_pos < b_header) begin
            drv = 1'b1;
            en  = 1'b1;
        end else if (n_bit_pos < b_turn) begin
            drv = n_header[hdr_off[3:0]];
            en  = 1'b1;
        end else if (n_bit_pos < b_data) begin
            en  = n_write_mode;
            drv = n_write_mode && (n_bit_pos == b_turn);
        end else if (n_bit_pos < b_idle) begin
            en  = n_write_mode;
            drv = n_write_mode && n_data_shift[dat_off[3:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= 1'b0;
            r_write_mode  <= 1'b0;
            r_bit_pos     <= 7'd0;
            r_tick_count  <= 10'd0;
            r_clock_level <= 1'b0;
            r_header      <= 14'd0;
            r_data_shift  <= 16'd0;
            r_captured    <= 16'd0;
        end else if (i_step) begin
            r_active      <= n_active;
            r_write_mode  <= n_write_mode;
            r_bit_pos     <= n_bit_pos;
            r_tick_count  <= n_tick_count;
            r_clock_level <= n_clock_level;
            r_header      <= n_header;
            r_data_shift  <= n_data_shift;
            r_captured    <= n_captured;
        end
    end

    assign o_res.mdc_level        = n_active & n_clock_level;
    assign o_res.mdio_drive       = drv;
    assign o_res.mdio_enable      = en;
    assign o_res.busy_res         = n_active;
    assign o_res.frame_done       = done;
    assign o_res.read_value       = n_captured;
    assign o_res.command_rejected = rejected;

endmodule

FILE: hdl/mdio_management_master_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdio_management_master_core
// Clause-22 MDIO management master driven by a beat stream of ticks and
// commands, one result beat per input beat.
// ----------------------------------------------------------------------------
// Each input beat is either a time tick (tuser 0) or a start command
// (tuser 1). Every beat returns exactly one result beat holding the pin
// levels (MDC, MDIO drive and enable) and status after that beat. Commands
// that arrive while a frame is running are flagged and dropped. A frame is
// one idle MDC period, preamble_ones periods of one (capped at 32), ST,
// opcode, PHY and register address, turnaround and 16 data bits, then two
// idle periods; MDC toggles every half_period_ticks tick beats. Throughput is
// one beat per clock while the consumer takes results: a beat lands in an
// input register, the frame engine updates state and forms the result in one
// pass, and the result sits in an output register, which the beat enters once
// that register is empty or being drained. While a result waits for the
// consumer one more beat can enter the input register; after that s_tready
// stays low until the consumer takes the result. Registers: half_period_ticks
// at byte 0x0, preamble_ones at byte 0x4.
// ----------------------------------------------------------------------------
module mdio_management_master_core
    import mdiomm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // is_write, phy_address[4:0],
                                   // register_address[4:0], write_value[15:0],
                                   // mdio_sample, zero pad
    input  logic [0:0]  s_tuser,   // kind
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // mdc_level, mdio_drive, mdio_enable,
                                   // busy_res, read_value[15:0],
                                   // command_rejected, zero pad
    output logic        m_tlast,   // frame_done
    // config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg    cfg;
    t_item   item_in;
    t_item   r_item;
    logic    r_in_valid;
    t_result res;
    t_result r_res;
    logic    r_out_valid;
    logic    advance;
    logic    step;

    mdiomm_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Unpack the input beat
    assign item_in.kind             = t_kind'(s_tuser[0]);
    assign item_in.is_write         = s_tdata[0];
    assign item_in.phy_address      = s_tdata[5:1];
    assign item_in.register_address = s_tdata[10:6];
    assign item_in.write_value      = s_tdata[26:11];
    assign item_in.mdio_sample      = s_tdata[27];

    // Output register moves when empty or being drained; input stage follows.
    assign advance  = !r_out_valid || m_tready;
    assign step     = r_in_valid && advance;
    assign s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_item <= item_in;
        end
    end

    mdiomm_frame_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tlast  = r_res.frame_done;
    assign m_tdata  = {3'd0, r_res.command_rejected, r_res.read_value,
                       r_res.busy_res, r_res.mdio_enable, r_res.mdio_drive,
                       r_res.mdc_level};

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Clause-22 MDIO management master core: a
// frame-level model predicts every result beat (pin levels, busy, frame
// done, read data, reject flag) from the accepted tick and command beats,
// under bursty input, a stalling consumer and several register settings.
// ----------------------------------------------------------------------------
import mdiomm_pkg::*;

// Frame-level model of the master plus the queue of result beats it owes.
class mdio_frame_scoreboard;
    logic [9:0]  half_period;
    logic [5:0]  preamble;
    bit          active;
    bit          write_mode;
    bit [6:0]    slot;
    bit [9:0]    tick_count;
    bit          mdc_high;
    bit [13:0]   header;
    bit [15:0]   data_shift;
    bit [15:0]   captured;
    t_result     pending_results[$];
    int          errors;

    function void clear();
        half_period = C_HALF_PERIOD_RESET;
        preamble    = C_PREAMBLE_RESET;
        active      = 1'b0;
        write_mode  = 1'b0;
        slot        = '0;
        tick_count  = '0;
        mdc_high    = 1'b0;
        header      = '0;
        data_shift  = '0;
        captured    = '0;
        errors      = 0;
        pending_results.delete();
    endfunction

    function void set_register(t_reg_index idx, logic [31:0] value);
        if (idx == REG_HALF_PERIOD) begin
            half_period = value[9:0];
        end else begin
            preamble = value[5:0];
        end
    endfunction

    function int unsigned preamble_len();
        return (preamble > C_MAX_PREAMBLE) ? C_MAX_PREAMBLE : preamble;
    endfunction

    // Advance the model by one accepted input beat and queue its result.
    function void note_input(t_item it);
        int unsigned p;
        int unsigned pos;
        int unsigned hp;
        t_result     r;
        bit          done;
        bit          rejected;
        bit          en;
        bit          lvl;
        done     = 1'b0;
        rejected = 1'b0;
        if (it.kind == KIND_COMMAND) begin
            if (active) begin
                rejected = 1'b1;
            end else begin
                write_mode = it.is_write;
                header     = {(it.is_write ? C_CODE_WRITE : C_CODE_READ),
                              it.phy_address, it.register_address};
                data_shift = it.is_write ? it.write_value : 16'h0000;
                active     = 1'b1;
                slot       = '0;
                tick_count = '0;
                mdc_high   = 1'b0;
            end
        end else if (active) begin
            hp = (half_period == 0) ? 1 : half_period;
            tick_count = tick_count + 10'd1;
            if (tick_count >= hp) begin
                tick_count = '0;
                if (!mdc_high) begin
                    // rising edge: read data slots sample the pin
                    p = preamble_len();
                    if (!write_mode && slot >= 17 + p && slot < 33 + p)
                        data_shift = {data_shift[14:0], it.mdio_sample};
                    mdc_high = 1'b1;
                end else begin
                    mdc_high = 1'b0;
                    slot     = slot + 7'd1;
                    if (slot >= preamble_len() + 35) begin
                        if (!write_mode)
                            captured = data_shift;
                        active = 1'b0;
                        slot   = '0;
                        done   = 1'b1;
                    end
                end
            end
        end

        // pin levels for the slot now current
        p   = preamble_len();
        pos = slot;
        en  = 1'b0;
        lvl = 1'b0;
        if (active && pos != 0) begin
            if (pos < 1 + p) begin
                en  = 1'b1;
                lvl = 1'b1;
            end else if (pos < 15 + p) begin
                en  = 1'b1;
                lvl = header[13 - (pos - 1 - p)];
            end else if (pos < 17 + p) begin
                en  = write_mode;
                lvl = write_mode && (pos == 15 + p);
            end else if (pos < 33 + p) begin
                en  = write_mode;
                lvl = write_mode && data_shift[15 - (pos - 17 - p)];
            end
        end

        r.mdc_level        = active && mdc_high;
        r.mdio_drive       = lvl;
        r.mdio_enable      = en;
        r.busy_res         = active;
        r.frame_done       = done;
        r.read_value       = captured;
        r.command_rejected = rejected;
        pending_results.push_back(r);
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    function void check_result(t_result got);
        t_result want;
        if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: result beat with nothing pending, expected none, actual %h",
                     $time, got);
            return;
        end
        want = pending_results.pop_front();
        check_field("mdc_level", 16'(want.mdc_level), 16'(got.mdc_level));
        check_field("mdio_drive", 16'(want.mdio_drive), 16'(got.mdio_drive));
        check_field("mdio_enable", 16'(want.mdio_enable), 16'(got.mdio_enable));
        check_field("busy_res", 16'(want.busy_res), 16'(got.busy_res));
        check_field("frame_done", 16'(want.frame_done), 16'(got.frame_done));
        check_field("read_value", want.read_value, got.read_value);
        check_field("command_rejected", 16'(want.command_rejected),
                    16'(got.command_rejected));
    endfunction
endclass

module tb_top;

    localparam int CYCLE_LIMIT  = 400000;  // many times the slowest clean run
    localparam int HOLD_CYCLES  = 300;     // long consumer hold-off
    localparam int PHASE_BEATS  = 40;      // counted random beats per register setting (idle ticks not counted)
    localparam int NUM_PHASES   = 2;

    // level fed back on MDIO during tick beats
    typedef enum int {
        SAMPLE_LOW,
        SAMPLE_HIGH,
        SAMPLE_RANDOM
    } t_sample_mode;

    // consumer stall patterns, rotated in turn
    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_HEAVY
    } t_stall_mode;

    logic        i_clk;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    mdio_frame_scoreboard sb = new();

    int unsigned cycle_count = 0;
    int          burst_left  = 0;
    bit          hold_request = 1'b0;
    bit          hold_done    = 1'b0;
    t_result     seen_result;

    mdio_management_master_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: a lost or stuck beat ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("mdio_management_master_core regression: fail");
            $finish;
        end
    end

    // Result monitor. m_tdata from bit 0: mdc_level, mdio_drive, mdio_enable,
    // busy_res, read_value[15:0], command_rejected; frame_done rides on tlast.
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            seen_result.mdc_level        = m_tdata[0];
            seen_result.mdio_drive       = m_tdata[1];
            seen_result.mdio_enable      = m_tdata[2];
            seen_result.busy_res         = m_tdata[3];
            seen_result.read_value       = m_tdata[19:4];
            seen_result.command_rejected = m_tdata[20];
            seen_result.frame_done       = m_tlast;
            sb.check_result(seen_result);
        end
    end

    // Consumer: rotating stall patterns, plus one long hold-off on request so
    // the core backs up and drops s_tready while the producer keeps offering.
    initial begin : consumer
        int unsigned cyc;
        t_stall_mode mode;
        cyc = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            mode = t_stall_mode'((cyc / 97) % 4);
            case (mode)
                STALL_NONE:     m_tready <= 1'b1;
                STALL_RANDOM:   m_tready <= 1'($urandom_range(0, 1));
                STALL_PERIODIC: m_tready <= (cyc % 5) != 0;
                default:        m_tready <= ($urandom_range(0, 3) == 0);
            endcase
            cyc++;
        end
    end

    // Offer one beat; bursts of random length with random gaps between them.
    // Returns right after the edge that accepts it, with the model updated.
    task automatic offer(input t_item it);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 16);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        // s_tdata from bit 0: is_write, phy_address, register_address,
        // write_value, mdio_sample, zero pad
        s_tdata  <= {4'b0000, it.mdio_sample, it.write_value, it.register_address,
                     it.phy_address, it.is_write};
        do @(posedge i_clk); while (!s_tready);
        sb.note_input(it);
    endtask

    function automatic t_item random_item();
        t_item it;
        it.kind             = $urandom_range(0, 1) ? KIND_COMMAND : KIND_TICK;
        it.is_write         = 1'($urandom_range(0, 1));
        it.phy_address      = 5'($urandom_range(0, 31));
        it.register_address = 5'($urandom_range(0, 31));
        it.write_value      = 16'($urandom_range(0, 65535));
        it.mdio_sample      = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic send_tick(input t_sample_mode mode);
        t_item it;
        it      = random_item();
        it.kind = KIND_TICK;
        if (mode != SAMPLE_RANDOM)
            it.mdio_sample = (mode == SAMPLE_HIGH);
        offer(it);
    endtask

    task automatic send_command(input logic wr, input logic [4:0] phy,
                                input logic [4:0] regad, input logic [15:0] value);
        t_item it;
        it                  = random_item();
        it.kind             = KIND_COMMAND;
        it.is_write         = wr;
        it.phy_address      = phy;
        it.register_address = regad;
        it.write_value      = value;
        offer(it);
    endtask

    // Tick until the running frame has ended.
    task automatic finish_frame(input t_sample_mode mode);
        while (sb.active) send_tick(mode);
    endtask

    // Stop offering and wait until every owed result beat has arrived.
    task automatic settle();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access; the write lands on the edge that
    // sees psel, penable, pwrite and pready together.
    task automatic write_register(input t_reg_index idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(idx, value);
    endtask

    task automatic configure(input logic [9:0] hp, input logic [5:0] pre);
        settle();
        write_register(REG_HALF_PERIOD, {22'd0, hp});
        write_register(REG_PREAMBLE, {26'd0, pre});
    endtask

    initial begin : producer
        logic [9:0]  phase_hp  [NUM_PHASES];
        logic [5:0]  phase_pre [NUM_PHASES];
        t_item       it;
        int          issued;
        phase_hp  = '{10'd1, 10'd0};
        phase_pre = '{6'd2, 6'd5};

        sb.clear();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed ----
        // zero half period runs as one tick
        configure(10'd0, 6'd0);
        // ticks while idle do nothing
        send_tick(SAMPLE_HIGH);
        send_tick(SAMPLE_LOW);
        // write with all-ones fields, plus a command rejected mid-frame
        send_command(1'b1, 5'd31, 5'd31, 16'hFFFF);
        repeat (5) send_tick(SAMPLE_RANDOM);
        send_command(1'b0, 5'd3, 5'd4, 16'h1234);
        finish_frame(SAMPLE_RANDOM);
        // read returning all ones
        configure(10'd1, 6'd0);
        send_command(1'b0, 5'd0, 5'd0, 16'h0000);
        finish_frame(SAMPLE_HIGH);

        // preamble past the cap saturates: run into the header, then shorten the
        // preamble so the slot index already lies in the shortened frame's trailing idle
        configure(10'd1, 6'd63);
        send_command(1'b0, 5'd21, 5'd10, 16'hA5A5);
        while (sb.active && sb.slot < 34) send_tick(SAMPLE_RANDOM);
        configure(10'd1, 6'd0);
        finish_frame(SAMPLE_RANDOM);

        // tick count already past a shortened half period; read of all zeros
        configure(10'd4, 6'd0);
        send_command(1'b0, 5'd31, 5'd0, 16'hFFFF);
        repeat (3) send_tick(SAMPLE_LOW);
        configure(10'd1, 6'd0);
        finish_frame(SAMPLE_LOW);

        // ---- random ----
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            configure(phase_hp[ph], phase_pre[ph]);
            if (ph == 1)
                hold_request = 1'b1;
            issued = 0;
            while (issued < PHASE_BEATS) begin
                it = random_item();
                // mostly frames being ticked out; some commands land on a busy core
                if (sb.active)
                    it.kind = ($urandom_range(0, 15) == 0) ? KIND_COMMAND : KIND_TICK;
                else
                    it.kind = ($urandom_range(0, 3) != 0) ? KIND_COMMAND : KIND_TICK;
                if (sb.active || it.kind == KIND_COMMAND)
                    issued++;
                offer(it);
            end
            finish_frame(SAMPLE_RANDOM);
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("mdio_management_master_core regression: pass");
        end else begin
            $display("mdio_management_master_core regression: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/mdiomm_pkg.sv
hdl/mdiomm_apb_regs.sv
hdl/mdiomm_frame_engine.sv
hdl/mdio_management_master_core.sv
bench/tb_top.sv
